// File: hw/rtl/lpr_pkg.sv
// lpr_pkg: shared widths, codes, request/command types and helpers for the
// line pixel rasterizer. No dependencies.
`default_nettype none

package lpr_pkg;

  localparam int unsigned COORD_BITS     = 10;
  localparam int unsigned ERR_BITS       = COORD_BITS + 1;
  localparam int unsigned COLOR_BITS     = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;  // power of two
  localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_BITS-1:0]   err_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef enum logic {
    OP_ADVANCE = 1'b0,
    OP_START   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_INC  = 2'd1,
    DIR_DEC  = 2'd3
  } dir_e;

  // Classified request as it waits in the queue.
  typedef struct packed {
    op_e    op;
    coord_t x_start;
    coord_t y_start;
    coord_t abs_dx;
    coord_t abs_dy;
    dir_e   dir_x;
    dir_e   dir_y;
    coord_t major_len;
    color_t color;
  } cmd_t;

  // One step of a coordinate along its direction, wrapping.
  function automatic coord_t axis_move(coord_t pos, dir_e dir);
    coord_t res;
    unique case (dir)
      DIR_INC: res = pos + coord_t'(1);
      DIR_DEC: res = pos - coord_t'(1);
      default: res = pos;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lpr_if.sv
// lpr_in_if / lpr_out_if: valid-ready channels of the line pixel rasterizer.
// Depends on lpr_pkg.
`default_nettype none

interface lpr_in_if;
  import lpr_pkg::*;

  logic   valid;
  logic   ready;
  logic   operation;
  coord_t x_start;
  coord_t y_start;
  coord_t x_end;
  coord_t y_end;
  color_t color;

  modport source (
    output valid, operation, x_start, y_start, x_end, y_end, color,
    input  ready
  );
  modport sink (
    input  valid, operation, x_start, y_start, x_end, y_end, color,
    output ready
  );
endinterface

interface lpr_out_if;
  import lpr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  color_t pixel_color;
  logic   last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/lpr_front.sv
// lpr_front: decodes an incoming request and works out direction, deltas
// and major length for a start. Depends on lpr_pkg.
`default_nettype none

module lpr_front (
  input  logic          operation_i,
  input  lpr_pkg::coord_t x_start_i,
  input  lpr_pkg::coord_t y_start_i,
  input  lpr_pkg::coord_t x_end_i,
  input  lpr_pkg::coord_t y_end_i,
  input  lpr_pkg::color_t color_i,
  output lpr_pkg::cmd_t   cmd_o
);
  import lpr_pkg::*;

  coord_t abs_dx, abs_dy;
  dir_e   dir_x, dir_y;

  always_comb begin
    if (x_end_i > x_start_i) begin
      abs_dx = x_end_i - x_start_i;
      dir_x  = DIR_INC;
    end else if (x_end_i < x_start_i) begin
      abs_dx = x_start_i - x_end_i;
      dir_x  = DIR_DEC;
    end else begin
      abs_dx = '0;
      dir_x  = DIR_HOLD;
    end
  end

  always_comb begin
    if (y_end_i > y_start_i) begin
      abs_dy = y_end_i - y_start_i;
      dir_y  = DIR_INC;
    end else if (y_end_i < y_start_i) begin
      abs_dy = y_start_i - y_end_i;
      dir_y  = DIR_DEC;
    end else begin
      abs_dy = '0;
      dir_y  = DIR_HOLD;
    end
  end

  always_comb begin
    cmd_o.op        = op_e'(operation_i);
    cmd_o.x_start   = x_start_i;
    cmd_o.y_start   = y_start_i;
    cmd_o.abs_dx    = abs_dx;
    cmd_o.abs_dy    = abs_dy;
    cmd_o.dir_x     = dir_x;
    cmd_o.dir_y     = dir_y;
    cmd_o.major_len = (abs_dx > abs_dy) ? abs_dx : abs_dy;
    cmd_o.color     = color_i;
  end

endmodule

`default_nettype wire

// File: hw/rtl/lpr_queue.sv
// lpr_queue: small FIFO of classified requests between front and back.
// Depends on lpr_pkg.
`default_nettype none

module lpr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  lpr_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output lpr_pkg::cmd_t pop_cmd_o
);
  import lpr_pkg::*;

  cmd_t                      mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_BITS-1:0] count_q, count_d;
  logic                      push, pop;

  assign push_ready_o = (count_q != QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QUEUE_PTR_BITS'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QUEUE_PTR_BITS'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + QUEUE_CNT_BITS'(1);
    end else if (pop && !push) begin
      count_d = count_q - QUEUE_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue empty with pointers apart");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/lpr_back.sv
// lpr_back: line state, per-pixel error accumulator step and output
// register. Depends on lpr_pkg.
`default_nettype none

module lpr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  lpr_pkg::cmd_t   cmd_i,
  output logic            pix_valid_o,
  input  logic            pix_ready_i,
  output lpr_pkg::coord_t pix_x_o,
  output lpr_pkg::coord_t pix_y_o,
  output lpr_pkg::color_t pix_color_o,
  output logic            pix_last_o
);
  import lpr_pkg::*;

  logic   active_q, active_d;
  coord_t cur_col_q, cur_col_d;
  coord_t cur_row_q, cur_row_d;
  err_t   err_x_q, err_x_d;
  err_t   err_y_q, err_y_d;
  coord_t abs_dx_q, abs_dy_q;
  dir_e   dir_x_q, dir_y_q;
  coord_t major_len_q;
  coord_t step_index_q, step_index_d;
  color_t held_color_q;

  logic   out_valid_q, out_valid_d;
  coord_t out_x_q, out_y_q;
  color_t out_color_q;
  logic   out_last_q;

  logic   pop, start, emit, last;
  coord_t b_col, b_row, b_dx, b_dy, b_major, b_step;
  err_t   b_err_x, b_err_y, sum_x, sum_y, major_ext;
  dir_e   b_dir_x, b_dir_y;
  color_t b_color;

  assign cmd_ready_o = !out_valid_q || pix_ready_i;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign start       = (cmd_i.op == OP_START);
  assign emit        = pop && (start || active_q);

  // Start requests step from fresh state, advances from the registers.
  always_comb begin
    b_col   = start ? cmd_i.x_start   : cur_col_q;
    b_row   = start ? cmd_i.y_start   : cur_row_q;
    b_err_x = start ? '0              : err_x_q;
    b_err_y = start ? '0              : err_y_q;
    b_dx    = start ? cmd_i.abs_dx    : abs_dx_q;
    b_dy    = start ? cmd_i.abs_dy    : abs_dy_q;
    b_dir_x = start ? cmd_i.dir_x     : dir_x_q;
    b_dir_y = start ? cmd_i.dir_y     : dir_y_q;
    b_major = start ? cmd_i.major_len : major_len_q;
    b_step  = start ? '0              : step_index_q;
    b_color = start ? cmd_i.color     : held_color_q;
  end

  always_comb begin
    last      = (b_step == b_major);
    major_ext = {1'b0, b_major};
    sum_x     = b_err_x + {1'b0, b_dx};
    sum_y     = b_err_y + {1'b0, b_dy};
    err_x_d   = sum_x;
    err_y_d   = sum_y;
    cur_col_d = b_col;
    cur_row_d = b_row;
    if (sum_x > major_ext) begin
      err_x_d   = sum_x - major_ext;
      cur_col_d = axis_move(b_col, b_dir_x);
    end
    if (sum_y > major_ext) begin
      err_y_d   = sum_y - major_ext;
      cur_row_d = axis_move(b_row, b_dir_y);
    end
    step_index_d = b_step + coord_t'(1);
    active_d     = !last;
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pix_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      err_x_q      <= '0;
      err_y_q      <= '0;
      abs_dx_q     <= '0;
      abs_dy_q     <= '0;
      dir_x_q      <= DIR_HOLD;
      dir_y_q      <= DIR_HOLD;
      major_len_q  <= '0;
      step_index_q <= '0;
      held_color_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (emit) begin
        active_q     <= active_d;
        cur_col_q    <= cur_col_d;
        cur_row_q    <= cur_row_d;
        err_x_q      <= err_x_d;
        err_y_q      <= err_y_d;
        abs_dx_q     <= b_dx;
        abs_dy_q     <= b_dy;
        dir_x_q      <= b_dir_x;
        dir_y_q      <= b_dir_y;
        major_len_q  <= b_major;
        step_index_q <= step_index_d;
        held_color_q <= b_color;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_x_q     <= b_col;
      out_y_q     <= b_row;
      out_color_q <= b_color;
      out_last_q  <= last;
    end
  end

  assign pix_valid_o = out_valid_q;
  assign pix_x_o     = out_x_q;
  assign pix_y_o     = out_y_q;
  assign pix_color_o = out_color_q;
  assign pix_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (step_index_q <= major_len_q))
    else $error("step index ran past line length");
  a_err_x_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_x_q <= {1'b0, major_len_q})
    else $error("x accumulator above distance");
  a_err_y_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_y_q <= {1'b0, major_len_q})
    else $error("y accumulator above distance");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last) |=> !active_q)
    else $error("line still active after last pixel");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/line_pixel_rasterizer.sv
// line_pixel_rasterizer: top level, front decode -> request queue -> pixel
// stepper. Depends on lpr_pkg, lpr_if, lpr_front, lpr_queue, lpr_back.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+----------------------------------------
//  req_i    | in  | valid / ready   | operation, x/y start, x/y end, color
//  pix_o    | out | valid / ready   | pixel_x, pixel_y, pixel_color, last_pixel
//
// One request per cycle sustained while pix_o does not stall; each start or in-line
// advance yields one pixel in the cycle after it leaves the queue (output register).
// The per-pixel add/compare/subtract on the accumulators sets the rate.
// A 2-deep request queue decouples decode from stepping; req_i.ready drops
// only when the queue is full, i.e. when pix_o stalls long enough.
// Async active-low reset clears the queue, line state and output valid.
`default_nettype none

module line_pixel_rasterizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpr_in_if.sink     req_i,
  lpr_out_if.source  pix_o
);
  import lpr_pkg::*;

  cmd_t front_cmd;   // classified request, straight from decode
  cmd_t queue_cmd;   // head of queue
  logic queue_valid;
  logic back_ready;

  // Front: direction, deltas and major length for start requests.
  lpr_front u_front (
    .operation_i (req_i.operation),
    .x_start_i   (req_i.x_start),
    .y_start_i   (req_i.y_start),
    .x_end_i     (req_i.x_end),
    .y_end_i     (req_i.y_end),
    .color_i     (req_i.color),
    .cmd_o       (front_cmd)
  );

  // Queue: lets the input side keep taking requests during output stalls.
  lpr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (req_i.valid),
    .push_ready_o (req_i.ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (queue_cmd)
  );

  // Back: holds the running line; advances while idle are dropped here.
  lpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (queue_cmd),
    .pix_valid_o (pix_o.valid),
    .pix_ready_i (pix_o.ready),
    .pix_x_o     (pix_o.pixel_x),
    .pix_y_o     (pix_o.pixel_y),
    .pix_color_o (pix_o.pixel_color),
    .pix_last_o  (pix_o.last_pixel)
  );

endmodule

`default_nettype wire

// File: bench/line_pixel_rasterizer_tb.sv
// line_pixel_rasterizer_tb: self-checking bench for the line pixel rasterizer.
// Drives line start / advance requests with random gaps and stalls and checks
// every pixel against an in-bench line stepper. Depends on lpr_pkg and lpr_if.

module line_pixel_rasterizer_tb;
  import lpr_pkg::*;

  // Cycles with no handshake on either channel before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  // Least number of requests queued in the random phase.
  localparam int RANDOM_REQS = 620;
  // Major-axis length of the one long line in the random phase.
  localparam int LONG_SPAN   = 255;

  typedef struct {
    op_e    op;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    color_t color;
  } line_req_t;

  typedef struct {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  logic clk;
  logic rst_n;

  lpr_in_if  req_if ();
  lpr_out_if pix_if ();

  line_pixel_rasterizer i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .pix_o  (pix_if)
  );

  line_req_t pending_reqs[$];     // requests still to be offered
  line_req_t in_flight;           // request currently on req_if
  pixel_t    expected_pixels[$];  // pixels predicted, not yet seen
  int        reqs_total;
  int        reqs_accepted;
  int        mismatches;
  int        quiet_cycles;
  int        req_gap;
  int        pix_stall;
  logic      calm;                // no idling on either side while set
  int        calm_timer;

  // Line stepper state, mirrors what the block keeps between requests.
  logic   line_busy;
  coord_t cur_x, cur_y;
  err_t   acc_x, acc_y;
  coord_t span_x, span_y, span_major;
  dir_e   step_x, step_y;
  coord_t pix_index;
  color_t line_color;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Line stepper
  // ------------------------------------------------------------------

  function automatic void axis_span(input coord_t from, input coord_t to,
                                    output coord_t span, output dir_e dir);
    if (to > from) begin
      span = to - from;
      dir  = DIR_INC;
    end else if (to < from) begin
      span = from - to;
      dir  = DIR_DEC;
    end else begin
      span = '0;
      dir  = DIR_HOLD;
    end
  endfunction

  function automatic coord_t nudge(coord_t pos, dir_e dir);
    case (dir)
      DIR_INC: return pos + coord_t'(1);
      DIR_DEC: return pos - coord_t'(1);
      default: return pos;
    endcase
  endfunction

  // Queue the current pixel, then run both accumulators one step.
  task automatic plot_and_step();
    pixel_t px;
    px.x     = cur_x;
    px.y     = cur_y;
    px.color = line_color;
    px.last  = (pix_index == span_major);
    expected_pixels.push_back(px);
    acc_x = acc_x + err_t'(span_x);
    acc_y = acc_y + err_t'(span_y);
    // strict compare: an accumulator equal to the distance does not step
    if (acc_x > err_t'(span_major)) begin
      acc_x = acc_x - err_t'(span_major);
      cur_x = nudge(cur_x, step_x);
    end
    if (acc_y > err_t'(span_major)) begin
      acc_y = acc_y - err_t'(span_major);
      cur_y = nudge(cur_y, step_y);
    end
    pix_index = pix_index + coord_t'(1);
    line_busy = !px.last;
  endtask

  task automatic rasterize_request(line_req_t r);
    if (r.op == OP_START) begin
      // a start drops whatever line is running
      axis_span(r.x_start, r.x_end, span_x, step_x);
      axis_span(r.y_start, r.y_end, span_y, step_y);
      span_major = (span_x > span_y) ? span_x : span_y;
      cur_x      = r.x_start;
      cur_y      = r.y_start;
      acc_x      = '0;
      acc_y      = '0;
      pix_index  = '0;
      line_color = r.color;
      line_busy  = 1'b1;
      plot_and_step();
    end else if (line_busy) begin
      plot_and_step();
    end
    // advance with no line running: nothing comes out
  endtask

  // ------------------------------------------------------------------
  // Idling
  // ------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      calm       <= 1'b0;
      calm_timer <= 0;
    end else if (calm_timer == 0) begin
      calm       <= ($urandom_range(0, 3) == 0);
      calm_timer <= $urandom_range(50, 300);
    end else begin
      calm_timer <= calm_timer - 1;
    end
  end

  // ------------------------------------------------------------------
  // Request driver
  // ------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid     <= 1'b0;
      req_if.operation <= OP_ADVANCE;
      req_if.x_start   <= '0;
      req_if.y_start   <= '0;
      req_if.x_end     <= '0;
      req_if.y_end     <= '0;
      req_if.color     <= '0;
      req_gap          <= 0;
    end else if (!req_if.valid || req_if.ready) begin
      // request taken at this edge: predict what it yields
      if (req_if.valid) begin
        rasterize_request(in_flight);
        reqs_accepted++;
      end
      if (req_gap > 0 || pending_reqs.size() == 0) begin
        if (req_gap > 0) req_gap <= req_gap - 1;
        req_if.valid <= 1'b0;
      end else begin
        in_flight = pending_reqs.pop_front();
        req_if.valid     <= 1'b1;
        req_if.operation <= in_flight.op;
        req_if.x_start   <= in_flight.x_start;
        req_if.y_start   <= in_flight.y_start;
        req_if.x_end     <= in_flight.x_end;
        req_if.y_end     <= in_flight.y_end;
        req_if.color     <= in_flight.color;
        req_gap          <= pick_gap();
      end
    end
  end

  // ------------------------------------------------------------------
  // Pixel monitor
  // ------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf("unexpected pixel (%0d,%0d)", pix_if.pixel_x,
                                pix_if.pixel_y));
      return;
    end
    want = expected_pixels.pop_front();
    if (pix_if.pixel_x !== want.x)
      report_mismatch($sformatf("pixel_x %0d, expected %0d", pix_if.pixel_x, want.x));
    if (pix_if.pixel_y !== want.y)
      report_mismatch($sformatf("pixel_y %0d, expected %0d", pix_if.pixel_y, want.y));
    if (pix_if.pixel_color !== want.color)
      report_mismatch($sformatf("pixel_color %h, expected %h", pix_if.pixel_color,
                                want.color));
    if (pix_if.last_pixel !== want.last)
      report_mismatch($sformatf("last_pixel %b, expected %b at (%0d,%0d)",
                                pix_if.last_pixel, want.last, want.x, want.y));
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pix_if.ready <= 1'b0;
      pix_stall    <= 0;
    end else begin
      if (pix_if.valid && pix_if.ready) check_pixel();
      if (pix_stall > 0) begin
        pix_stall    <= pix_stall - 1;
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= 1'b1;
        pix_stall    <= pick_gap();
      end
    end
  end

  // ------------------------------------------------------------------
  // Watchdog: any handshake resets the quiet count
  // ------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (pix_if.valid && pix_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("line_pixel_rasterizer_tb failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------

  task automatic queue_start(int xs, int ys, int xe, int ye, int col);
    line_req_t r;
    r.op      = OP_START;
    r.x_start = coord_t'(xs);
    r.y_start = coord_t'(ys);
    r.x_end   = coord_t'(xe);
    r.y_end   = coord_t'(ye);
    r.color   = color_t'(col);
    pending_reqs.push_back(r);
  endtask

  // advance requests carry random leftover coordinates; the block ignores them
  task automatic queue_advances(int n);
    line_req_t r;
    repeat (n) begin
      r.op      = OP_ADVANCE;
      r.x_start = coord_t'($urandom);
      r.y_start = coord_t'($urandom);
      r.x_end   = coord_t'($urandom);
      r.y_end   = coord_t'($urandom);
      r.color   = color_t'($urandom);
      pending_reqs.push_back(r);
    end
  endtask

  // end point at distance d from p, kept on the panel
  function automatic int end_from(int p, int d);
    int max_coord;
    max_coord = (1 << COORD_BITS) - 1;
    if ($urandom_range(0, 1) && p + d <= max_coord) return p + d;
    if (p >= d) return p - d;
    return p + d;
  endfunction

  initial begin
    int counted;
    int xs, ys, dx, dy, line_len, span, n_adv, r;
    bit long_done;
    int max_coord;

    max_coord = (1 << COORD_BITS) - 1;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.operation = OP_ADVANCE;
    req_if.x_start = '0;
    req_if.y_start = '0;
    req_if.x_end = '0;
    req_if.y_end = '0;
    req_if.color = '0;
    pix_if.ready = 1'b0;
    line_busy = 1'b0;
    reqs_accepted = 0;
    mismatches = 0;

    // -- directed: corner cases --
    queue_advances(1);                                    // advance straight out of reset
    queue_start(max_coord, max_coord, max_coord, max_coord, 16'hFFFF);  // single pixel line
    queue_advances(1);                                    // idle again afterwards
    queue_start(0, 0, 3, 1, 16'h0000);                    // shallow, +x +y
    queue_advances(3);
    queue_start(5, 0, 0, 2, 16'hA5A5);                    // -x +y, cut short below
    queue_advances(2);
    queue_start(0, max_coord, 2, max_coord - 3, 16'h5A5A); // steep -y, abandons the line above
    queue_advances(3);
    queue_advances(1);                                    // advance past the last pixel
    queue_start(7, 7, 7, 9, 16'h07E0);                    // vertical
    queue_advances(2);
    queue_start(max_coord, 0, max_coord - 2, 0, 16'hF81F); // horizontal, -x
    queue_advances(2);

    // -- random: mostly complete lines, some cut short, some overrun, some noise --
    counted = 0;
    long_done = 1'b0;
    while (counted < RANDOM_REQS) begin
      xs = $urandom_range(0, max_coord);
      ys = $urandom_range(0, max_coord);
      r  = $urandom_range(0, 99);
      if (!long_done && counted > RANDOM_REQS / 2) begin
        // one long line, run to its last pixel
        long_done = 1'b1;
        queue_start(0, ys, LONG_SPAN, end_from(ys, $urandom_range(0, LONG_SPAN)),
                    $urandom_range(0, 65535));
        queue_advances(LONG_SPAN);
        counted += 1 + LONG_SPAN;
      end else if (r < 85) begin
        span = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 160);
        dx = $urandom_range(0, span);
        dy = $urandom_range(0, span);
        if ($urandom_range(0, 1)) dx = span;
        else dy = span;
        line_len = span;
        queue_start(xs, ys, end_from(xs, dx), end_from(ys, dy), $urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (r < 80) n_adv = line_len;
        else if (r < 90) n_adv = $urandom_range(0, line_len);
        else n_adv = line_len + $urandom_range(1, 3);
        queue_advances(n_adv);
        counted += 1 + n_adv;
      end else begin
        // noise: fully random endpoints, dropped after a few pixels
        queue_start(xs, ys, $urandom_range(0, max_coord), $urandom_range(0, max_coord),
                    $urandom_range(0, 65535));
        n_adv = $urandom_range(0, 4);
        queue_advances(n_adv);
        counted += 1 + n_adv;
      end
    end
    reqs_total = pending_reqs.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (reqs_accepted == reqs_total);
    while (expected_pixels.size() != 0) @(posedge clk);
    // catch any stray pixel behind the last one
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("line_pixel_rasterizer_tb passed");
    end else begin
      $display("line_pixel_rasterizer_tb failed");
    end
    $finish;
  end

endmodule
